FILE: design/ldb_pkg.sv
package ldb_pkg;

  localparam int MAX_BATCH    = 16;
  localparam int FILTER_DEPTH = 64;
  localparam int KEY_WIDTH    = 64;

  localparam int FLT_AW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int PB_AW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int PB_CW  = $clog2(MAX_BATCH + 1);

  localparam logic [2:0] ACT_LEARN = 3'd0;
  localparam logic [2:0] ACT_ACK1  = 3'd1;
  localparam logic [2:0] ACT_ACKB  = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [1:0] REG_BATCH_LIMIT = 2'd0;
  localparam logic [1:0] REG_TIMEOUT     = 2'd1;
  localparam logic [1:0] REG_LIST        = 2'd2;

  typedef logic [KEY_WIDTH-1:0] key_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] sample_key;
    logic [15:0] ack_batch;
    logic [3:0]  ack_position;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_list;
    logic [15:0] batch_number;
    logic [4:0]  batch_size;
    logic [3:0]  sample_position;
    logic [63:0] sample_value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    key_t        key;
    logic [15:0] batch;
    logic [3:0]  pos;
  } flt_ent_t;

  typedef struct packed {
    logic              capture;
    logic              exec;
    logic              rd_en;
    logic [FLT_AW-1:0] rd_addr;
    logic              commit;
    logic              emit_load;
    logic [PB_CW-1:0]  emit_idx;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       action;
    logic             learn_emit;
    logic             tick_flush;
    logic [PB_CW-1:0] pend_cnt;
    logic             out_free;
  } sts_t;

endpackage

FILE: design/ldb_if.sv
interface ldb_in_if;
  logic              valid;
  logic              ready;
  ldb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ldb_out_if;
  logic               valid;
  logic               ready;
  ldb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/ldb_ctrl.sv
module ldb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ldb_pkg::sts_t sts,
  output ldb_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LAST   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [ldb_pkg::FLT_AW-1:0] idx_r, idx_nxt;
  logic [ldb_pkg::PB_CW-1:0]  k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_addr  = idx_r;
    cmd.emit_idx = k_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.action)
          ldb_pkg::ACT_LEARN, ldb_pkg::ACT_ACK1, ldb_pkg::ACT_ACKB: begin
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end
          ldb_pkg::ACT_TICK: begin
            k_nxt     = '0;
            state_nxt = sts.tick_flush ? S_EMIT : S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (idx_r == ldb_pkg::FLT_AW'(ldb_pkg::FILTER_DEPTH - 1)) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LAST: state_nxt = S_COMMIT;
      S_COMMIT: begin
        cmd.commit = 1'b1;
        k_nxt      = '0;
        if (sts.action == ldb_pkg::ACT_LEARN && sts.learn_emit) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (k_r + 1'b1 == sts.pend_cnt) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/ldb_dpath.sv
module ldb_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  ldb_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  ldb_pkg::cmd_t      cmd,
  output ldb_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_ready,
  output ldb_pkg::out_item_t out_data
);

  logic [4:0]  lim_r;
  logic [15:0] tmo_r;
  logic [7:0]  list_r;

  logic [2:0]        act_r;
  ldb_pkg::key_t     key_r;
  logic [15:0]       ab_r;
  logic [3:0]        ap_r;

  ldb_pkg::flt_ent_t flt_mem [ldb_pkg::FILTER_DEPTH];
  ldb_pkg::flt_ent_t rd_q_r;
  logic                       cmp_vld_r;
  logic [ldb_pkg::FLT_AW-1:0] cmp_idx_r;
  logic [ldb_pkg::FILTER_DEPTH-1:0] vld_r, vld_nxt;
  logic                       dup_r, dup_nxt;
  logic                       fnd_r, fnd_nxt;
  logic [ldb_pkg::FLT_AW-1:0] free_r, free_nxt;

  ldb_pkg::key_t pend_r [ldb_pkg::MAX_BATCH];
  logic [ldb_pkg::PB_CW-1:0] cnt_r, cnt_nxt;
  logic [15:0] bcnt_r, bcnt_nxt;
  logic [15:0] age_r, age_nxt;

  logic               out_vld_r;
  ldb_pkg::out_item_t out_r;

  logic        ent_vld, hit_key, hit_b, hit_p;
  logic        store;
  logic [7:0]  eff_lim, cnt_inc;
  logic [15:0] age_inc;
  logic        flush;
  logic        emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r  <= 5'd1;
      tmo_r  <= '0;
      list_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ldb_pkg::REG_BATCH_LIMIT: lim_r  <= cfg_wdata[4:0];
        ldb_pkg::REG_TIMEOUT:     tmo_r  <= cfg_wdata;
        ldb_pkg::REG_LIST:        list_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_data.action;
      key_r <= in_data.sample_key[ldb_pkg::KEY_WIDTH-1:0];
      ab_r  <= in_data.ack_batch;
      ap_r  <= in_data.ack_position;
    end
  end

  assign ent_vld = cmp_vld_r && vld_r[cmp_idx_r];
  assign hit_key = ent_vld && (rd_q_r.key == key_r);
  assign hit_b   = ent_vld && (rd_q_r.batch == ab_r);
  assign hit_p   = hit_b && (rd_q_r.pos == ap_r);

  assign eff_lim = (lim_r == 5'd0) ? 8'd1 :
                   (8'(lim_r) > 8'(ldb_pkg::MAX_BATCH)) ? 8'(ldb_pkg::MAX_BATCH) : 8'(lim_r);
  assign cnt_inc = 8'(cnt_r) + 8'd1;
  assign store   = (act_r == ldb_pkg::ACT_LEARN) && !dup_r && fnd_r &&
                   (8'(cnt_r) < 8'(ldb_pkg::MAX_BATCH));
  assign age_inc = (age_r == 16'hFFFF) ? age_r : age_r + 16'd1;
  assign flush   = (cnt_r != '0) && (tmo_r != 16'd0) && (age_inc >= tmo_r);
  assign emit_last = cmd.emit_load && (cmd.emit_idx + 1'b1 == cnt_r);

  always_comb begin
    sts            = '0;
    sts.action     = act_r;
    sts.learn_emit = store && (cnt_inc >= eff_lim);
    sts.tick_flush = flush;
    sts.pend_cnt   = cnt_r;
    sts.out_free   = !out_vld_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && store) begin
      flt_mem[free_r] <= '{key: key_r, batch: bcnt_r, pos: 4'(cnt_r)};
      pend_r[cnt_r[ldb_pkg::PB_AW-1:0]] <= key_r;
    end
    if (cmd.rd_en) begin
      rd_q_r <= flt_mem[cmd.rd_addr];
    end
    cmp_idx_r <= cmd.rd_addr;
  end

  always_comb begin
    vld_nxt  = vld_r;
    dup_nxt  = dup_r;
    fnd_nxt  = fnd_r;
    free_nxt = free_r;
    cnt_nxt  = cnt_r;
    bcnt_nxt = bcnt_r;
    age_nxt  = age_r;
    if (cmd.exec) begin
      dup_nxt = 1'b0;
      fnd_nxt = 1'b0;
      if (act_r == ldb_pkg::ACT_TICK && cnt_r != '0) begin
        age_nxt = age_inc;
      end
      if (act_r == ldb_pkg::ACT_CLEAR) begin
        vld_nxt  = '0;
        cnt_nxt  = '0;
        bcnt_nxt = '0;
        age_nxt  = '0;
      end
    end
    if (cmp_vld_r) begin
      case (act_r)
        ldb_pkg::ACT_LEARN: begin
          if (hit_key) begin
            dup_nxt = 1'b1;
          end
          if (!vld_r[cmp_idx_r] && !fnd_r) begin
            fnd_nxt  = 1'b1;
            free_nxt = cmp_idx_r;
          end
        end
        ldb_pkg::ACT_ACK1: if (hit_p) vld_nxt[cmp_idx_r] = 1'b0;
        ldb_pkg::ACT_ACKB: if (hit_b) vld_nxt[cmp_idx_r] = 1'b0;
        default: ;
      endcase
    end
    if (cmd.commit && store) begin
      vld_nxt[free_r] = 1'b1;
      cnt_nxt         = cnt_r + 1'b1;
      if (cnt_r == '0) begin
        age_nxt = '0;
      end
    end
    if (emit_last) begin
      bcnt_nxt = bcnt_r + 16'd1;
      cnt_nxt  = '0;
      age_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      cmp_vld_r <= 1'b0;
      dup_r     <= 1'b0;
      fnd_r     <= 1'b0;
      free_r    <= '0;
      cnt_r     <= '0;
      bcnt_r    <= '0;
      age_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      cmp_vld_r <= cmd.rd_en;
      dup_r     <= dup_nxt;
      fnd_r     <= fnd_nxt;
      free_r    <= free_nxt;
      cnt_r     <= cnt_nxt;
      bcnt_r    <= bcnt_nxt;
      age_r     <= age_nxt;
      if (cmd.emit_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_r.out_list        <= list_r;
      out_r.batch_number    <= bcnt_r;
      out_r.batch_size      <= 5'(cnt_r);
      out_r.sample_position <= 4'(cmd.emit_idx);
      out_r.sample_value    <= 64'(pend_r[cmd.emit_idx[ldb_pkg::PB_AW-1:0]]);
      out_r.last            <= emit_last;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: design/learn_digest_dedup_batcher_unit.sv
// Learn digest filter and batcher. Learn and acknowledge items take the
// filter search path: one filter entry is read per cycle from a single-port
// memory, so a learn or an acknowledge is captured, executed, then scans all
// FILTER_DEPTH entries before it commits; a learn that completes a batch then
// emits each sample as the output frees. A tick runs without a search and
// emits the pending samples when it flushes. Results leave through an output
// register, so the next item is taken while a batch's last beat still waits.
module learn_digest_dedup_batcher_unit (
  input  logic        clk,
  input  logic        rst_n,
  ldb_in_if.sink      in_chan,
  ldb_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  ldb_pkg::cmd_t cmd;
  ldb_pkg::sts_t sts;

  ldb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ldb_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_chan.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
  );

endmodule

FILE: design/ldb_checker.sv
module ldb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ldb_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last ==
      ((5'(out_data.sample_position) + 5'd1) == out_data.batch_size)))
    else $error("last flag disagrees with position and size");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (5'(out_data.sample_position) < out_data.batch_size))
    else $error("sample position beyond batch size");

endmodule

bind learn_digest_dedup_batcher_unit ldb_checker u_ldb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
